// File: design/ltr_pkg.sv
// Shared types and constants for the lock table with revoke and retry.
package ltr_pkg;

    localparam int LOCK_IDX_BITS   = 4;
    localparam int CLIENT_IDX_BITS = 3;
    localparam int XID_PORT_BITS   = 32;
    localparam int STATUS_BITS     = 3;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic KIND_REVOKE = 1'b0;
    localparam logic KIND_RETRY  = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_RETRY     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_RPCERR    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOENT     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOTHOLDER = 3'd4;

    typedef struct packed {
        logic load;
        logic commit;
    } ltr_cmd_t;

    typedef struct packed {
        logic out_free;
    } ltr_stat_t;

endpackage

// File: design/ltr_ctrl.sv
// Controller: sequences request capture and table update for one transaction.
module ltr_ctrl
    import ltr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ltr_stat_t stat,
    output ltr_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/ltr_datapath.sv
// Datapath: lock tables, per-pair reply memory, update logic and result register.
module ltr_datapath
    import ltr_pkg::*;
#(
    parameter int LOCK_COUNT   = 16,
    parameter int CLIENT_COUNT = 8,
    parameter int XID_BITS     = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ltr_cmd_t                   cmd,
    output ltr_stat_t                  stat,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       op,
    input  logic [LOCK_IDX_BITS-1:0]   lock_index,
    input  logic [CLIENT_IDX_BITS-1:0] client_index,
    input  logic [XID_PORT_BITS-1:0]   request_xid,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_BITS-1:0]     status,
    output logic                       notify_valid,
    output logic                       notify_kind,
    output logic [CLIENT_IDX_BITS-1:0] notify_client,
    output logic [LOCK_IDX_BITS-1:0]   notify_lock,
    output logic [XID_PORT_BITS-1:0]   notify_xid
);

    localparam int PAIRS       = LOCK_COUNT * CLIENT_COUNT;
    localparam int LOCK_BITS   = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int CLIENT_BITS = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
    localparam int PAIR_BITS   = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    typedef struct packed {
        logic [XID_BITS-1:0]    hx;
        logic [STATUS_BITS-1:0] acq;
        logic                   rel_v;
        logic [STATUS_BITS-1:0] rel;
    } entry_t;

    // tables
    logic                    primary_mode_reg;
    logic [LOCK_COUNT-1:0]   lock_present_reg;
    logic [LOCK_COUNT-1:0]   holder_valid_reg;
    logic [CLIENT_BITS-1:0]  holder_client_reg [LOCK_COUNT];
    logic [CLIENT_COUNT-1:0] waiting_reg [LOCK_COUNT];
    logic [PAIRS-1:0]        xid_seen_reg;
    entry_t                  mem [PAIRS];

    // captured request
    logic                   op_reg;
    logic [LOCK_BITS-1:0]   lk_reg;
    logic [CLIENT_BITS-1:0] cl_reg;
    logic [XID_BITS-1:0]    xid_reg;
    logic                   range_ok_reg;
    logic [PAIR_BITS-1:0]   p_reg;
    logic [CLIENT_BITS-1:0] tgt_reg;
    entry_t                 rd_a_reg;
    entry_t                 rd_b_reg;

    // result register
    logic                       out_valid_reg;
    logic [STATUS_BITS-1:0]     status_reg;
    logic                       nvalid_reg;
    logic                       nkind_reg;
    logic [CLIENT_IDX_BITS-1:0] nclient_reg;
    logic [LOCK_IDX_BITS-1:0]   nlock_reg;
    logic [XID_PORT_BITS-1:0]   nxid_reg;

    // request-side lookup
    logic [LOCK_BITS-1:0]    lk_in;
    logic [CLIENT_BITS-1:0]  cl_in;
    logic [CLIENT_COUNT-1:0] wm_in;
    logic [CLIENT_BITS-1:0]  low_in;
    logic [CLIENT_BITS-1:0]  tgt_in;
    logic                    range_in;
    logic [PAIR_BITS-1:0]    p_in;
    logic [PAIR_BITS-1:0]    tp_in;

    always_comb
    begin
        lk_in    = LOCK_BITS'(lock_index);
        cl_in    = CLIENT_BITS'(client_index);
        range_in = (int'(lock_index) < LOCK_COUNT) && (int'(client_index) < CLIENT_COUNT);
        wm_in    = waiting_reg[lk_in];
        low_in   = '0;
        for (int i = CLIENT_COUNT - 1; i >= 0; i--)
        begin
            if (wm_in[i])
            begin
                low_in = CLIENT_BITS'(i);
            end
        end
        tgt_in = (op == OP_ACQUIRE) ? holder_client_reg[lk_in] : low_in;
        p_in   = PAIR_BITS'(int'(lk_in) * CLIENT_COUNT + int'(cl_in));
        tp_in  = PAIR_BITS'(int'(lk_in) * CLIENT_COUNT + int'(tgt_in));
    end

    // update logic
    logic                    seen;
    entry_t                  ent;
    entry_t                  ent_new;
    logic                    hv;
    logic [CLIENT_BITS-1:0]  hc;
    logic [CLIENT_COUNT-1:0] wm;
    logic [CLIENT_COUNT-1:0] cl_bit;
    logic [STATUS_BITS-1:0]  st_c;
    logic                    nv;
    logic                    nkind;
    logic [CLIENT_BITS-1:0]  ncl;
    logic [XID_BITS-1:0]     nx;
    logic                    mem_wr;
    logic                    set_present;
    logic                    hold_wr;
    logic                    hv_new;
    logic [CLIENT_BITS-1:0]  hc_new;
    logic                    wait_wr;
    logic [CLIENT_COUNT-1:0] wm_new;
    logic                    gate;

    always_comb
    begin
        seen          = xid_seen_reg[p_reg];
        ent           = seen ? rd_a_reg : '0;
        hv            = holder_valid_reg[lk_reg];
        hc            = holder_client_reg[lk_reg];
        wm            = waiting_reg[lk_reg];
        cl_bit        = '0;
        cl_bit[cl_reg] = 1'b1;
        st_c          = ST_RPCERR;
        nv            = 1'b0;
        nkind         = KIND_REVOKE;
        ncl           = '0;
        nx            = '0;
        mem_wr        = 1'b0;
        ent_new       = ent;
        set_present   = 1'b0;
        hold_wr       = 1'b0;
        hv_new        = hv;
        hc_new        = hc;
        wait_wr       = 1'b0;
        wm_new        = wm;
        if (range_ok_reg)
        begin
            if (op_reg == OP_ACQUIRE)
            begin
                set_present = 1'b1;
                if (!seen || (ent.hx < xid_reg))
                begin
                    mem_wr        = 1'b1;
                    ent_new.hx    = xid_reg;
                    ent_new.rel_v = 1'b0;
                    ent_new.rel   = '0;
                    wait_wr       = 1'b1;
                    if (hv)
                    begin
                        st_c   = ST_RETRY;
                        wm_new = wm | cl_bit;
                        nv     = 1'b1;
                        ncl    = hc;
                        nx     = (hc == cl_reg) ? xid_reg : rd_b_reg.hx;
                    end
                    else
                    begin
                        st_c    = ST_OK;
                        hold_wr = 1'b1;
                        hv_new  = 1'b1;
                        hc_new  = cl_reg;
                        wm_new  = wm & ~cl_bit;
                        nv      = |(wm & ~cl_bit);
                        ncl     = cl_reg;
                        nx      = xid_reg;
                    end
                    ent_new.acq = st_c;
                end
                else if (ent.hx == xid_reg)
                begin
                    st_c = ent.acq;
                end
            end
            else
            begin
                if (!lock_present_reg[lk_reg])
                begin
                    st_c = ST_NOENT;
                end
                else if (!seen || (xid_reg < ent.hx))
                begin
                    st_c = ST_RPCERR;
                end
                else if (ent.rel_v)
                begin
                    st_c = ent.rel;
                end
                else if (!hv || (hc != cl_reg))
                begin
                    st_c          = ST_NOTHOLDER;
                    mem_wr        = 1'b1;
                    ent_new.rel_v = 1'b1;
                    ent_new.rel   = ST_NOTHOLDER;
                end
                else
                begin
                    st_c          = ST_OK;
                    mem_wr        = 1'b1;
                    ent_new.rel_v = 1'b1;
                    ent_new.rel   = ST_OK;
                    hold_wr       = 1'b1;
                    hv_new        = 1'b0;
                    hc_new        = '0;
                    nv            = |wm;
                    nkind         = KIND_RETRY;
                    ncl           = tgt_reg;
                    nx            = rd_b_reg.hx;
                end
            end
        end
        gate = nv & primary_mode_reg;
    end

    assign stat.out_free = !out_valid_reg || out_ready;

    // capture request and read the reply memory
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op;
            lk_reg       <= lk_in;
            cl_reg       <= cl_in;
            xid_reg      <= XID_BITS'(request_xid);
            range_ok_reg <= range_in;
            p_reg        <= p_in;
            tgt_reg      <= tgt_in;
            rd_a_reg     <= mem[p_in];
            rd_b_reg     <= mem[tp_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && mem_wr)
        begin
            mem[p_reg] <= ent_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_mode_reg  <= 1'b1;
            lock_present_reg  <= '0;
            holder_valid_reg  <= '0;
            holder_client_reg <= '{default: '0};
            waiting_reg       <= '{default: '0};
            xid_seen_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                primary_mode_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                if (set_present)
                begin
                    lock_present_reg[lk_reg] <= 1'b1;
                end
                if (mem_wr)
                begin
                    xid_seen_reg[p_reg] <= 1'b1;
                end
                if (hold_wr)
                begin
                    holder_valid_reg[lk_reg]  <= hv_new;
                    holder_client_reg[lk_reg] <= hc_new;
                end
                if (wait_wr)
                begin
                    waiting_reg[lk_reg] <= wm_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= st_c;
            nvalid_reg  <= gate;
            nkind_reg   <= gate ? nkind : 1'b0;
            nclient_reg <= gate ? CLIENT_IDX_BITS'(ncl) : '0;
            nlock_reg   <= gate ? LOCK_IDX_BITS'(lk_reg) : '0;
            nxid_reg    <= gate ? XID_PORT_BITS'(nx) : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign notify_valid  = nvalid_reg;
    assign notify_kind   = nkind_reg;
    assign notify_client = nclient_reg;
    assign notify_lock   = nlock_reg;
    assign notify_xid    = nxid_reg;

endmodule

// File: design/lock_table_with_revoke_retry_top.sv
// Top level of the lock table with revoke and retry notifications.
//
// Input channel (in_valid/in_ready) carries one acquire or release transaction:
// op, lock_index, client_index, request_xid. Output channel (out_valid/out_ready)
// returns exactly one result transaction per request: status plus an optional
// revoke or retry notification (notify_*), zeroed when none is sent.
// cfg_we/cfg_wdata write primary_mode; while it is 0 notifications are dropped.
// The request and its reply-memory reads are registered on acceptance, and the
// result is registered when the update commits: a capture step reads the
// per-pair reply memory and lock tables, an update step writes them and loads
// the result. in_ready is high only between transactions.
// Reset clears all lock and pair tables (pair entries through per-entry seen
// bits) and sets primary_mode to 1; no clearing sweep is needed.
// When the receiver stalls, the update waits until the output register frees;
// one result may sit in the output register while the next request is taken.
module lock_table_with_revoke_retry_top
    import ltr_pkg::*;
#(
    parameter int LOCK_COUNT   = 16,
    parameter int CLIENT_COUNT = 8,
    parameter int XID_BITS     = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       op,
    input  logic [LOCK_IDX_BITS-1:0]   lock_index,
    input  logic [CLIENT_IDX_BITS-1:0] client_index,
    input  logic [XID_PORT_BITS-1:0]   request_xid,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_BITS-1:0]     status,
    output logic                       notify_valid,
    output logic                       notify_kind,
    output logic [CLIENT_IDX_BITS-1:0] notify_client,
    output logic [LOCK_IDX_BITS-1:0]   notify_lock,
    output logic [XID_PORT_BITS-1:0]   notify_xid
);

    ltr_cmd_t  cmd;
    ltr_stat_t stat;

    ltr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ltr_datapath #(
        .LOCK_COUNT   (LOCK_COUNT),
        .CLIENT_COUNT (CLIENT_COUNT),
        .XID_BITS     (XID_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .op            (op),
        .lock_index    (lock_index),
        .client_index  (client_index),
        .request_xid   (request_xid),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .notify_valid  (notify_valid),
        .notify_kind   (notify_kind),
        .notify_client (notify_client),
        .notify_lock   (notify_lock),
        .notify_xid    (notify_xid)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous transaction in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && notify_valid |-> status == ST_OK || status == ST_RETRY)
        else $error("notification with error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && notify_valid && notify_kind == KIND_RETRY |-> status == ST_OK)
        else $error("retry notification without successful release");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !notify_valid |-> notify_xid == '0 && notify_client == '0)
        else $error("notification fields not cleared");

endmodule
